[src/pfss_pkg.sv]
// Package for the frame sync search: shared types, CRC-16-CCITT helpers and
// configuration register indexes. No dependencies.
package pfss_pkg;

    typedef logic [7:0]        data8_t;
    typedef logic [15:0]       crc_t;
    typedef logic [15:0][15:0] crc_map_t;

    localparam crc_t CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        CFG_SYNC_HIGH    = 3'd0,
        CFG_SYNC_LOW     = 3'd1,
        CFG_FRAME_TYPE   = 3'd2,
        CFG_PAYLOAD_LEN  = 3'd3,
        CFG_CRC_INITIAL  = 3'd4
    } cfg_idx_t;

    localparam data8_t RST_SYNC_HIGH   = 8'd235;
    localparam data8_t RST_SYNC_LOW    = 8'd144;
    localparam data8_t RST_FRAME_TYPE  = 8'd1;
    localparam data8_t RST_PAYLOAD_LEN = 8'd45;
    localparam crc_t   RST_CRC_INITIAL = 16'hFFFF;

    // one byte through the CRC register, MSB first
    function automatic crc_t crc_byte(input crc_t c, input data8_t b);
        crc_t r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    // linear map of the CRC register over n zero bytes, one column per bit
    function automatic crc_map_t crc_zero_map(input int n);
        crc_map_t m;
        crc_t     v;
        for (int j = 0; j < 16; j++)
        begin
            v = crc_t'(1) << j;
            for (int k = 0; k < n; k++)
            begin
                v = crc_byte(v, 8'h00);
            end
            m[j] = v;
        end
        return m;
    endfunction

    function automatic crc_t crc_map_apply(input crc_map_t m, input crc_t v);
        crc_t r;
        r = '0;
        for (int j = 0; j < 16; j++)
        begin
            if (v[j])
            begin
                r = r ^ m[j];
            end
        end
        return r;
    endfunction

endpackage

[src/pcm_frame_sync_search_top.sv]
// Top level of the PCM frame sync search: config registers, byte counter,
// check stage and output register. Depends on pfss_pkg and pfss_cell.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------
//  in       | in_valid / in_stall | data_byte, last_byte
//  out      | out_valid/out_stall | found, frame_offset
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle while in_stall is low. A byte shifts the cell row on its
// accept edge; the frame check on the shifted window fires into the output
// register when out_stall allows, raising out_valid on a hit or last byte.
// in_stall rises only while a checked byte waits on a full, stalled output.
// rst_n clears counters and flags and resets config regs; no clearing pass.
module pcm_frame_sync_search_top #(
    parameter int FRAME_BYTES      = 55,
    parameter int CRC_SPAN_BYTES   = 53,
    parameter int MAX_BUFFER_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [15:0] frame_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pfss_pkg::*;

    localparam int CW = $clog2(MAX_BUFFER_BYTES + 1);
    localparam int DW = ((CW > 16) ? CW : 16) + 1;
    localparam int SPAN_IN_WIN = (CRC_SPAN_BYTES < FRAME_BYTES) ? CRC_SPAN_BYTES : FRAME_BYTES;
    localparam crc_map_t ZERO_TAIL_MAP = crc_zero_map(CRC_SPAN_BYTES - SPAN_IN_WIN);
    localparam crc_map_t INIT_MAP      = crc_zero_map(CRC_SPAN_BYTES);

    data8_t sync_high_reg;
    data8_t sync_low_reg;
    data8_t frame_type_reg;
    data8_t payload_len_reg;
    crc_t   crc_initial_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] count_inc;
    logic [DW-1:0] off_diff;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          s1_elig_reg;
    logic          s1_last_reg;
    logic [15:0]   s1_off_reg;
    logic          done_reg;
    logic          done_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          found_reg;
    logic [15:0]   frame_offset_reg;

    logic          accept;
    logic          shift_en;
    logic          elig;
    logic          fire;
    logic          hit;
    logic          emit;

    data8_t        win_byte [FRAME_BYTES];
    crc_t          win_crc  [FRAME_BYTES];
    data8_t        b6;
    data8_t        b7;
    data8_t        crc_lo;
    data8_t        crc_hi;
    crc_t          span_crc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_high_reg   <= RST_SYNC_HIGH;
            sync_low_reg    <= RST_SYNC_LOW;
            frame_type_reg  <= RST_FRAME_TYPE;
            payload_len_reg <= RST_PAYLOAD_LEN;
            crc_initial_reg <= RST_CRC_INITIAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SYNC_HIGH:   sync_high_reg   <= cfg_data[7:0];
                CFG_SYNC_LOW:    sync_low_reg    <= cfg_data[7:0];
                CFG_FRAME_TYPE:  frame_type_reg  <= cfg_data[7:0];
                CFG_PAYLOAD_LEN: payload_len_reg <= cfg_data[7:0];
                CFG_CRC_INITIAL: crc_initial_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // cell row: index 0 oldest; the CRC partials enter at the newest end
    genvar p;
    generate
        for (p = 0; p < FRAME_BYTES; p++)
        begin : g_cell
            data8_t byte_src;
            crc_t   crc_src;
            if (p == FRAME_BYTES - 1)
            begin : g_head
                assign byte_src = data_byte;
                assign crc_src  = '0;
            end
            else
            begin : g_body
                assign byte_src = win_byte[p+1];
                assign crc_src  = win_crc[p+1];
            end
            pfss_cell #(
                .ACCUM (p >= FRAME_BYTES - SPAN_IN_WIN)
            ) u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .byte_in  (byte_src),
                .data_new (data_byte),
                .crc_in   (crc_src),
                .byte_q   (win_byte[p]),
                .crc_q    (win_crc[p])
            );
        end

        if (6 < FRAME_BYTES)
        begin : g_b6
            assign b6 = win_byte[6];
        end
        else
        begin : g_b6z
            assign b6 = '0;
        end

        if (7 < FRAME_BYTES)
        begin : g_b7
            assign b7 = win_byte[7];
        end
        else
        begin : g_b7z
            assign b7 = '0;
        end

        if (CRC_SPAN_BYTES < FRAME_BYTES)
        begin : g_clo
            assign crc_lo = win_byte[CRC_SPAN_BYTES];
        end
        else
        begin : g_cloz
            assign crc_lo = '0;
        end

        if (CRC_SPAN_BYTES + 1 < FRAME_BYTES)
        begin : g_chi
            assign crc_hi = win_byte[CRC_SPAN_BYTES+1];
        end
        else
        begin : g_chiz
            assign crc_hi = '0;
        end
    endgenerate

    // stage 1: count and offset of the byte being accepted
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign shift_en = accept && (count_reg < CW'(MAX_BUFFER_BYTES));
    assign count_inc = count_reg + CW'(1);
    assign off_diff  = DW'(count_inc) - DW'(FRAME_BYTES);
    assign elig = shift_en && (count_inc >= CW'(FRAME_BYTES)) && (off_diff[DW-1:16] == '0);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (last_byte)
                count_next = '0;
            else if (shift_en)
                count_next = count_inc;
        end
    end

    // stage 2: frame check on the shifted window
    assign span_crc = crc_map_apply(ZERO_TAIL_MAP, win_crc[0]) ^
                      crc_map_apply(INIT_MAP, crc_initial_reg);
    assign hit  = s1_elig_reg && !done_reg &&
                  (win_byte[0] == sync_high_reg) && (win_byte[1] == sync_low_reg) &&
                  (b6 == frame_type_reg) && (b7 == payload_len_reg) &&
                  (span_crc == {crc_hi, crc_lo});
    assign fire = s1_valid_reg && !(out_valid_reg && out_stall);
    assign emit = hit || (s1_last_reg && !done_reg);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;

        done_next = done_reg;
        if (fire)
            done_next = s1_last_reg ? 1'b0 : (done_reg || hit);

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (fire && emit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            s1_valid_reg  <= s1_valid_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_elig_reg <= elig;
            s1_last_reg <= last_byte;
            s1_off_reg  <= off_diff[15:0];
        end
        if (fire && emit)
        begin
            found_reg        <= hit;
            frame_offset_reg <= hit ? s1_off_reg : 16'h0000;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign frame_offset = frame_offset_reg;

endmodule

[src/pfss_cell.sv]
// One window cell: a byte of the window and a partial CRC word.
// Depends on pfss_pkg.
module pfss_cell #(
    parameter bit ACCUM = 1'b1
) (
    input  logic           clk,
    input  logic           shift_en,
    input  pfss_pkg::data8_t byte_in,
    input  pfss_pkg::data8_t data_new,
    input  pfss_pkg::crc_t   crc_in,
    output pfss_pkg::data8_t byte_q,
    output pfss_pkg::crc_t   crc_q
);
    import pfss_pkg::*;

    data8_t byte_reg;
    crc_t   crc_reg;
    crc_t   crc_next;

    // accumulating cells add the newest byte; the rest form a delay line
    always_comb
    begin
        if (ACCUM)
            crc_next = crc_byte(crc_in, data_new);
        else
            crc_next = crc_in;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
            crc_reg  <= crc_next;
        end
    end

    assign byte_q = byte_reg;
    assign crc_q  = crc_reg;

endmodule
